FILE: src/twtls_pkg.sv
package twtls_pkg;

  localparam int TICK_MS = 10;
  localparam int SCAN_MS = 250;
  localparam int SECOND_MS = 1000;
  localparam int MS_PER_S = 1000;

  localparam int MS_W = 17;
  localparam int PHASE_TICK_W = 14;
  localparam int SCAN_TICK_W = 5;
  localparam int SECOND_TICK_W = 7;
  localparam int SEC_W = 8;

  localparam int PHASE_TICK_MAX = (1 << PHASE_TICK_W) - 1;
  localparam int SCAN_TICKS_RAW = SCAN_MS / TICK_MS;
  localparam int SECOND_TICKS_RAW = SECOND_MS / TICK_MS;
  localparam int SCAN_TICKS = (SCAN_TICKS_RAW > (1 << SCAN_TICK_W) - 1) ?
                              (1 << SCAN_TICK_W) - 1 : SCAN_TICKS_RAW;
  localparam int SECOND_TICKS = (SECOND_TICKS_RAW > (1 << SECOND_TICK_W) - 1) ?
                                (1 << SECOND_TICK_W) - 1 : SECOND_TICKS_RAW;

  // ms / TICK_MS as a multiply by a rounded-up reciprocal, exact over 17 bits
  localparam int TICK_SHIFT = 25;
  localparam int TICK_RECIP_W = 26;
  localparam int TICK_RECIP = ((1 << TICK_SHIFT) + TICK_MS - 1) / TICK_MS;
  localparam int TICK_PROD_W = MS_W + TICK_RECIP_W;

  // ms / 1000, exact over 17 bits
  localparam int SEC_SHIFT = 27;
  localparam int SEC_RECIP_W = 18;
  localparam int SEC_RECIP = ((1 << SEC_SHIFT) + MS_PER_S - 1) / MS_PER_S;
  localparam int SEC_PROD_W = MS_W + SEC_RECIP_W;

  localparam int RED_RESET_MS = 5000;
  localparam int GREEN_RESET_MS = 3000;
  localparam int YELLOW_RESET_MS = 2000;

  localparam int IN_TDATA_W = 8;
  localparam int OUT_TDATA_W = 24;

  typedef enum logic [1:0] {
    PH_INIT   = 2'd0,
    PH_RED    = 2'd1,
    PH_GREEN  = 2'd2,
    PH_YELLOW = 2'd3
  } phase_t;

  localparam logic [1:0] REG_RED = 2'd0;
  localparam logic [1:0] REG_GREEN = 2'd1;
  localparam logic [1:0] REG_YELLOW = 2'd2;

  localparam logic [2:0] LAMPS_OFF = 3'd7;
  localparam logic [2:0] LAMPS_RED = 3'd6;
  localparam logic [2:0] LAMPS_GREEN = 3'd5;
  localparam logic [2:0] LAMPS_YELLOW = 3'd3;

  localparam logic [3:0] DIGITS_OFF = 4'hF;

  // Remaining time kept as decimal seconds plus a flag for a nonzero ms part
  typedef struct packed {
    logic       hund;
    logic [3:0] tens;
    logic [3:0] units;
    logic       frac;
  } rem_t;

  typedef struct packed {
    logic [PHASE_TICK_W-1:0] ticks;
    rem_t                    rem;
  } dur_t;

  typedef struct packed {
    phase_t                  phase;
    logic [PHASE_TICK_W-1:0] ticks;
    rem_t                    rem;
  } dir_t;

  // Split a constant duration into its decimal form
  function automatic rem_t rem_of_ms(int ms);
    rem_t r;
    int sec;
    sec = ms / MS_PER_S;
    r.hund = (sec >= 100);
    r.tens = 4'((sec % 100) / 10);
    r.units = 4'(sec % 10);
    r.frac = ((ms % MS_PER_S) != 0);
    return r;
  endfunction

  localparam dur_t RED_RESET = '{
    ticks: PHASE_TICK_W'(RED_RESET_MS / TICK_MS),
    rem:   rem_of_ms(RED_RESET_MS)
  };
  localparam dur_t GREEN_RESET = '{
    ticks: PHASE_TICK_W'(GREEN_RESET_MS / TICK_MS),
    rem:   rem_of_ms(GREEN_RESET_MS)
  };
  localparam dur_t YELLOW_RESET = '{
    ticks: PHASE_TICK_W'(YELLOW_RESET_MS / TICK_MS),
    rem:   rem_of_ms(YELLOW_RESET_MS)
  };

  function automatic logic [2:0] lamps_of(phase_t ph);
    logic [2:0] l;
    unique case (ph)
      PH_RED:    l = LAMPS_RED;
      PH_GREEN:  l = LAMPS_GREEN;
      PH_YELLOW: l = LAMPS_YELLOW;
      default:   l = LAMPS_OFF;
    endcase
    return l;
  endfunction

  function automatic logic [3:0] tens_shown(rem_t r);
    return r.hund ? 4'd9 : r.tens;
  endfunction

  // Drop one second, saturating at zero
  function automatic rem_t count_down(rem_t r);
    rem_t n;
    logic above;
    above = r.hund || (r.tens != 4'd0) || (r.units > 4'd1) ||
            ((r.units == 4'd1) && r.frac);
    n = r;
    if (!above) begin
      n = '0;
    end else if (r.units != 4'd0) begin
      n.units = r.units - 4'd1;
    end else begin
      n.units = 4'd9;
      if (r.tens != 4'd0) begin
        n.tens = r.tens - 4'd1;
      end else begin
        n.tens = 4'd9;
        n.hund = 1'b0;
      end
    end
    return n;
  endfunction

  function automatic dir_t step_dir(dir_t cur, phase_t first, logic restart,
                                    logic sec_fire, dur_t red, dur_t green,
                                    dur_t yellow);
    dir_t nxt;
    logic [PHASE_TICK_W-1:0] tk;
    logic load;
    phase_t ph;
    dur_t d;
    tk = (cur.ticks != '0) ? cur.ticks - PHASE_TICK_W'(1) : '0;
    nxt = cur;
    nxt.ticks = tk;
    load = 1'b0;
    ph = cur.phase;
    d = red;
    unique case (cur.phase)
      PH_INIT: begin
        load = 1'b1;
        ph = first;
        d = (first == PH_RED) ? red : green;
      end
      PH_RED: begin
        load = (tk == '0);
        ph = PH_GREEN;
        d = green;
      end
      PH_GREEN: begin
        load = (tk == '0);
        ph = PH_YELLOW;
        d = yellow;
      end
      default: begin
        load = (tk == '0);
        ph = PH_RED;
        d = red;
      end
    endcase
    priority if (restart) begin
      nxt.phase = PH_INIT;
    end else if (load) begin
      nxt.phase = ph;
      nxt.ticks = d.ticks;
      nxt.rem = d.rem;
    end
    if (sec_fire) begin
      nxt.rem = count_down(nxt.rem);
    end
    return nxt;
  endfunction

endpackage

FILE: src/two_way_traffic_light_sequencer.sv
// A result is registered and appears in the cycle after its tick item is accepted.
// Throughput: one tick item per cycle while results are taken; the result register frees as it is taken.
// A configuration write converts the duration through the cv_stage1 and cv_stage2 registers, and both
// input and configuration ready stay low during that time.
// Reset (rst, synchronous): both directions in init, counters at their
// reload values, display dark, durations at their defaults, no result held.
module two_way_traffic_light_sequencer import twtls_pkg::*; (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   s_tvalid,
  output logic                   s_tready,
  input  logic [IN_TDATA_W-1:0]  s_tdata,   // [0] restart
  output logic                   m_tvalid,
  input  logic                   m_tready,
  // [2:0] lamps_a, [5:3] lamps_b, [7:6] phase_a, [9:8] phase_b,
  // [13:10] digit_enables, [17:14] digit_value
  output logic [OUT_TDATA_W-1:0] m_tdata,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [1:0]             cfg_index,
  input  logic [MS_W-1:0]        cfg_data
);

  dur_t red_dur, green_dur, yellow_dur;
  dir_t dir_a, dir_b;
  logic [SCAN_TICK_W-1:0] scan_ticks;
  logic [SECOND_TICK_W-1:0] second_ticks;
  logic [1:0] digit_select;
  logic [3:0] shown_digit;
  logic [3:0] enable_pattern;

  // duration conversion pipeline
  logic cv_stage1, cv_stage2;
  logic [1:0] cv_index;
  logic [MS_W-1:0] cv_ms;
  logic [PHASE_TICK_W-1:0] cv_ticks;
  logic [SEC_W-1:0] cv_sec;

  logic in_accept;
  logic active;
  logic restart;
  logic [SCAN_TICK_W-1:0] scan_dec, scan_ticks_next;
  logic [SECOND_TICK_W-1:0] second_dec, second_ticks_next;
  logic scan_fire, sec_fire;
  logic [1:0] digit_select_next;
  logic [3:0] shown_digit_next, enable_pattern_next;
  dir_t dir_a_next, dir_b_next;

  logic [TICK_PROD_W-1:0] tick_prod;
  logic [MS_W-1:0] tick_q;
  logic [PHASE_TICK_W-1:0] tick_sat;
  logic [SEC_PROD_W-1:0] sec_prod;
  logic [MS_W:0] sec_back;
  logic [6:0] sec_low;
  logic [14:0] tens_prod;
  logic [3:0] cv_tens, cv_units;
  dur_t cv_dur;

  assign cfg_ready = !(cv_stage1 || cv_stage2);
  assign s_tready = cfg_ready && (!m_tvalid || m_tready);
  assign in_accept = s_tvalid && s_tready;
  assign restart = s_tdata[0];
  assign active = (dir_a.phase != PH_INIT) || (dir_b.phase != PH_INIT);

  always_comb begin
    scan_dec = (scan_ticks != '0) ? scan_ticks - SCAN_TICK_W'(1) : '0;
    second_dec = (second_ticks != '0) ? second_ticks - SECOND_TICK_W'(1) : '0;
    scan_fire = (scan_dec == '0) && active;
    sec_fire = (second_dec == '0);

    scan_ticks_next = scan_dec;
    digit_select_next = digit_select;
    enable_pattern_next = enable_pattern;
    shown_digit_next = shown_digit;
    if (scan_fire) begin
      scan_ticks_next = SCAN_TICK_W'(SCAN_TICKS);
      digit_select_next = digit_select + 2'd1;
      enable_pattern_next = DIGITS_OFF & ~(4'd1 << digit_select);
      unique case (digit_select)
        2'd0:    shown_digit_next = tens_shown(dir_a.rem);
        2'd1:    shown_digit_next = dir_a.rem.units;
        2'd2:    shown_digit_next = tens_shown(dir_b.rem);
        default: shown_digit_next = dir_b.rem.units;
      endcase
    end
    second_ticks_next = sec_fire ? SECOND_TICK_W'(SECOND_TICKS) : second_dec;

    dir_a_next = step_dir(dir_a, PH_RED, restart, sec_fire,
                          red_dur, green_dur, yellow_dur);
    dir_b_next = step_dir(dir_b, PH_GREEN, restart, sec_fire,
                          red_dur, green_dur, yellow_dur);
  end

  // Stage 1: ticks and whole seconds by reciprocal multiplies
  always_comb begin
    tick_prod = TICK_PROD_W'(cv_ms) * TICK_PROD_W'(TICK_RECIP);
    tick_q = tick_prod[TICK_SHIFT +: MS_W];
    tick_sat = (tick_q > MS_W'(PHASE_TICK_MAX)) ?
               PHASE_TICK_W'(PHASE_TICK_MAX) : tick_q[PHASE_TICK_W-1:0];
    sec_prod = SEC_PROD_W'(cv_ms) * SEC_PROD_W'(SEC_RECIP);
  end

  // Stage 2: split seconds into decimal digits, flag a leftover ms part
  always_comb begin
    sec_back = (MS_W+1)'(cv_sec) * (MS_W+1)'(MS_PER_S);
    cv_dur.ticks = cv_ticks;
    cv_dur.rem.hund = (cv_sec >= SEC_W'(100));
    sec_low = cv_dur.rem.hund ? 7'(cv_sec - SEC_W'(100)) : cv_sec[6:0];
    tens_prod = 15'(sec_low) * 15'd205;
    cv_tens = tens_prod[14:11];
    cv_units = 4'(sec_low - 7'(cv_tens) * 7'd10);
    cv_dur.rem.tens = cv_tens;
    cv_dur.rem.units = cv_units;
    cv_dur.rem.frac = (sec_back[MS_W-1:0] != cv_ms);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      red_dur <= RED_RESET;
      green_dur <= GREEN_RESET;
      yellow_dur <= YELLOW_RESET;
      dir_a <= '{phase: PH_INIT, ticks: '0, rem: '0};
      dir_b <= '{phase: PH_INIT, ticks: '0, rem: '0};
      scan_ticks <= SCAN_TICK_W'(SCAN_TICKS);
      second_ticks <= SECOND_TICK_W'(SECOND_TICKS);
      digit_select <= '0;
      shown_digit <= '0;
      enable_pattern <= DIGITS_OFF;
      m_tvalid <= 1'b0;
      cv_stage1 <= 1'b0;
      cv_stage2 <= 1'b0;
    end else begin
      cv_stage1 <= cfg_valid && cfg_ready;
      cv_stage2 <= cv_stage1;
      if (cv_stage2) begin
        unique case (cv_index)
          REG_RED:    red_dur <= cv_dur;
          REG_GREEN:  green_dur <= cv_dur;
          REG_YELLOW: yellow_dur <= cv_dur;
          default:    ;
        endcase
      end
      if (in_accept) begin
        dir_a <= dir_a_next;
        dir_b <= dir_b_next;
        scan_ticks <= scan_ticks_next;
        second_ticks <= second_ticks_next;
        digit_select <= digit_select_next;
        shown_digit <= shown_digit_next;
        enable_pattern <= enable_pattern_next;
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (cfg_valid && cfg_ready) begin
      cv_index <= cfg_index;
      cv_ms <= cfg_data;
    end
    if (cv_stage1) begin
      cv_ticks <= tick_sat;
      cv_sec <= sec_prod[SEC_SHIFT +: SEC_W];
    end
    if (in_accept) begin
      m_tdata <= {6'b0, shown_digit_next, enable_pattern_next,
                  dir_b_next.phase, dir_a_next.phase,
                  lamps_of(dir_b_next.phase), lamps_of(dir_a_next.phase)};
    end
  end

endmodule

FILE: src/twtls_checker.sv
module twtls_checker import twtls_pkg::*; (
  input logic                   clk,
  input logic                   rst,
  input logic                   s_tvalid,
  input logic                   s_tready,
  input logic                   m_tvalid,
  input logic                   m_tready,
  input logic [OUT_TDATA_W-1:0] m_tdata,
  input logic                   cfg_valid,
  input logic                   cfg_ready
);

  // lamps follow the phase codes of the same item
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata[2:0] == lamps_of(phase_t'(m_tdata[7:6]))) &&
                 (m_tdata[5:3] == lamps_of(phase_t'(m_tdata[9:8]))))
    else $error("lamps disagree with phase");

  // at most one digit enabled, and its value is decimal
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> $onehot0(~m_tdata[13:10]) && (m_tdata[17:14] <= 4'd9))
    else $error("bad display scan output");

  // a configuration write holds off ticks while it converts
  assert property (@(posedge clk) disable iff (rst)
    (cfg_valid && cfg_ready) |=> !s_tready && !cfg_ready)
    else $error("item accepted during duration conversion");

  // a stalled item holds
  assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |=> m_tvalid && $stable(m_tdata))
    else $error("result dropped or changed while stalled");

  // every accepted tick is answered in the next cycle
  assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> m_tvalid)
    else $error("tick item accepted without a result");

endmodule

bind two_way_traffic_light_sequencer twtls_checker u_twtls_checker (
  .clk       (clk),
  .rst       (rst),
  .s_tvalid  (s_tvalid),
  .s_tready  (s_tready),
  .m_tvalid  (m_tvalid),
  .m_tready  (m_tready),
  .m_tdata   (m_tdata),
  .cfg_valid (cfg_valid),
  .cfg_ready (cfg_ready)
);

FILE: dv/tb.sv
`timescale 1ns / 100ps

module tb;
  import twtls_pkg::*;

  localparam int CYCLE_LIMIT = 200000;
  localparam logic [1:0] REG_SPARE = 2'd3;

  typedef struct packed {
    phase_t                  phase;
    logic [PHASE_TICK_W-1:0] ticks;
    logic [MS_W-1:0]         rem;
  } light_t;

  typedef struct packed {
    logic [2:0] lamps_a;
    logic [2:0] lamps_b;
    phase_t     phase_a;
    phase_t     phase_b;
    logic [3:0] digit_enables;
    logic [3:0] digit_value;
  } lights_t;

  logic                   clk;
  logic                   rst;
  logic                   s_tvalid;
  logic                   s_tready;
  logic [IN_TDATA_W-1:0]  s_tdata;    // [0] restart
  logic                   m_tvalid;
  logic                   m_tready;
  // [2:0] lamps_a, [5:3] lamps_b, [7:6] phase_a, [9:8] phase_b,
  // [13:10] digit_enables, [17:14] digit_value
  logic [OUT_TDATA_W-1:0] m_tdata;
  logic                   cfg_valid;
  logic                   cfg_ready;
  logic [1:0]             cfg_index;
  logic [MS_W-1:0]        cfg_data;

  // predictor state
  light_t                   light_a;
  light_t                   light_b;
  logic [SCAN_TICK_W-1:0]   scan_cnt;
  logic [SECOND_TICK_W-1:0] second_cnt;
  logic [1:0]               digit_sel;
  logic [3:0]               digit_shown;
  logic [3:0]               digit_en;
  logic [MS_W-1:0]          dur_red;
  logic [MS_W-1:0]          dur_green;
  logic [MS_W-1:0]          dur_yellow;

  lights_t lights_due[$];

  int src_idle_pct;
  int sink_idle_pct;
  int failures;
  int cycles;
  int ticks_sent;
  int restarts_sent;
  int results_checked;
  int writes_done;
  int overflow_shown;

  two_way_traffic_light_sequencer dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycles++;
    if (cycles == CYCLE_LIMIT) begin
      $display("two_way_traffic_light_sequencer verification failed");
      $finish;
    end
  end

  always @(negedge clk) begin
    m_tready <= !rst && ($urandom_range(99, 0) >= sink_idle_pct);
  end

  function automatic logic [PHASE_TICK_W-1:0] ms_to_ticks(logic [MS_W-1:0] ms);
    int unsigned t;
    t = ms / TICK_MS;
    if (t > PHASE_TICK_MAX) t = PHASE_TICK_MAX;
    return PHASE_TICK_W'(t);
  endfunction

  function automatic light_t light_entering(phase_t ph, logic [MS_W-1:0] ms);
    light_t l;
    l.phase = ph;
    l.ticks = ms_to_ticks(ms);
    l.rem = ms;
    return l;
  endfunction

  function automatic light_t advance_light(light_t cur, phase_t first);
    light_t nxt;
    nxt = cur;
    case (cur.phase)
      PH_INIT: nxt = light_entering(first, (first == PH_RED) ? dur_red : dur_green);
      PH_RED: if (cur.ticks == '0) nxt = light_entering(PH_GREEN, dur_green);
      PH_GREEN: if (cur.ticks == '0) nxt = light_entering(PH_YELLOW, dur_yellow);
      default: if (cur.ticks == '0) nxt = light_entering(PH_RED, dur_red);
    endcase
    return nxt;
  endfunction

  function automatic logic [MS_W-1:0] drop_second(logic [MS_W-1:0] ms);
    return (ms > MS_W'(1000)) ? ms - MS_W'(1000) : '0;
  endfunction

  function automatic logic [2:0] lamp_code(phase_t ph);
    case (ph)
      PH_RED: return LAMPS_RED;
      PH_GREEN: return LAMPS_GREEN;
      PH_YELLOW: return LAMPS_YELLOW;
      default: return LAMPS_OFF;
    endcase
  endfunction

  // One timer tick: counters, then display scan on the old remaining times,
  // then phase step or restart, then the one-second countdown.
  function automatic lights_t next_lights(logic restart);
    lights_t r;
    logic active;
    logic [1:0] k;
    logic [MS_W-1:0] shown_rem;
    int unsigned tens;
    active = (light_a.phase != PH_INIT) || (light_b.phase != PH_INIT);
    if (light_a.ticks != '0) light_a.ticks = light_a.ticks - 1'b1;
    if (light_b.ticks != '0) light_b.ticks = light_b.ticks - 1'b1;
    if (scan_cnt != '0) scan_cnt = scan_cnt - 1'b1;
    if (second_cnt != '0) second_cnt = second_cnt - 1'b1;

    if (scan_cnt == '0 && active) begin
      k = digit_sel;
      scan_cnt = SCAN_TICK_W'(SCAN_TICKS);
      digit_sel = k + 2'd1;
      digit_en = ~(4'b0001 << k);
      shown_rem = k[1] ? light_b.rem : light_a.rem;
      tens = shown_rem / 10000;
      if (k[0]) begin
        digit_shown = 4'((shown_rem / 1000) % 10);
      end else if (tens > 9) begin
        digit_shown = 4'd9;
        overflow_shown++;
      end else begin
        digit_shown = 4'(tens);
      end
    end

    if (restart) begin
      light_a.phase = PH_INIT;
      light_b.phase = PH_INIT;
    end else begin
      light_a = advance_light(light_a, PH_RED);
      light_b = advance_light(light_b, PH_GREEN);
    end

    if (second_cnt == '0) begin
      second_cnt = SECOND_TICK_W'(SECOND_TICKS);
      light_a.rem = drop_second(light_a.rem);
      light_b.rem = drop_second(light_b.rem);
    end

    r.lamps_a = lamp_code(light_a.phase);
    r.lamps_b = lamp_code(light_b.phase);
    r.phase_a = light_a.phase;
    r.phase_b = light_b.phase;
    r.digit_enables = digit_en;
    r.digit_value = digit_shown;
    return r;
  endfunction

  function automatic void check_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      $error("%s: expected %0d, actual %0d", name, want, got);
      failures++;
    end
  endfunction

  always @(posedge clk) begin
    lights_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (lights_due.size() == 0) begin
        $error("result with no tick pending: tdata %h", m_tdata);
        failures++;
      end else begin
        want = lights_due.pop_front();
        check_field("lamps_a", want.lamps_a, m_tdata[2:0]);
        check_field("lamps_b", want.lamps_b, m_tdata[5:3]);
        check_field("phase_a", want.phase_a, m_tdata[7:6]);
        check_field("phase_b", want.phase_b, m_tdata[9:8]);
        check_field("digit_enables", want.digit_enables, m_tdata[13:10]);
        check_field("digit_value", want.digit_value, m_tdata[17:14]);
        results_checked++;
      end
    end
  end

  task automatic send_tick(input logic restart);
    while ($urandom_range(99, 0) < src_idle_pct) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= {{(IN_TDATA_W-1){1'b0}}, restart};
    do @(posedge clk); while (!s_tready);
    lights_due.push_back(next_lights(restart));
    ticks_sent++;
    if (restart) restarts_sent++;
    @(negedge clk);
  endtask

  task automatic run_ticks(input int n, input int restart_pct);
    repeat (n) send_tick($urandom_range(99, 0) < restart_pct);
  endtask

  // Hold off the sender until every pending result has been taken.
  task automatic drain();
    s_tvalid <= 1'b0;
    do @(negedge clk); while (lights_due.size() != 0);
  endtask

  task automatic set_durations(input logic [MS_W-1:0] red, green, yellow, spare);
    logic [MS_W-1:0] vals [4];
    vals = '{red, green, yellow, spare};
    drain();
    for (int i = 0; i < 4; i++) begin
      cfg_index <= 2'(i);
      cfg_data <= vals[i];
      cfg_valid <= 1'b1;
      do @(posedge clk); while (!cfg_ready);
      case (2'(i))
        REG_RED: dur_red = vals[i];
        REG_GREEN: dur_green = vals[i];
        REG_YELLOW: dur_yellow = vals[i];
        REG_SPARE: ;
      endcase
      writes_done++;
      @(negedge clk);
    end
    cfg_valid <= 1'b0;
  endtask

  function automatic logic [MS_W-1:0] short_ms();
    case ($urandom_range(0, 7))
      0: return '0;
      1: return MS_W'(1000);
      default: return MS_W'($urandom_range(0, 3000));
    endcase
  endfunction

  function automatic logic [MS_W-1:0] long_ms();
    case ($urandom_range(0, 3))
      0: return MS_W'(99000);
      1: return '1;
      default: return MS_W'($urandom_range(95000, 131071));
    endcase
  endfunction

  function automatic logic [MS_W-1:0] any_ms();
    case ($urandom_range(0, 3))
      0: return MS_W'($urandom_range(0, 131071));
      1: return long_ms();
      default: return short_ms();
    endcase
  endfunction

  function automatic logic [MS_W-1:0] spare_ms();
    return MS_W'($urandom_range(0, 131071));
  endfunction

  // Restart in init, defaults, restart while running, zero-length phases,
  // maximum durations and the ignored register index.
  task automatic test_directed_corners();
    repeat (2) send_tick(1'b1);
    repeat (3) send_tick(1'b0);
    send_tick(1'b1);
    send_tick(1'b0);
    set_durations('0, '0, '0, '1);
    send_tick(1'b1);
    repeat (6) send_tick(1'b0);
    set_durations('1, '1, '1, '0);
    send_tick(1'b1);
    repeat (4) send_tick(1'b0);
  endtask

  task automatic test_short_phases();
    repeat (4) begin
      set_durations(short_ms(), short_ms(), short_ms(), spare_ms());
      run_ticks(90, 2);
      drain();
      run_ticks(90, 2);
    end
  endtask

  // Long red (95 s up to the 17-bit maximum) can put A's remaining time above 99 s, where its tens digit saturates.
  task automatic test_long_red_overflow();
    repeat (2) begin
      set_durations(long_ms(), short_ms(), short_ms(), spare_ms());
      send_tick(1'b1);
      run_ticks(300, 1);
    end
  endtask

  task automatic test_full_rate_mix();
    repeat (4) begin
      set_durations(any_ms(), any_ms(), any_ms(), spare_ms());
      run_ticks(170, 3);
    end
  endtask

  initial begin
    clk = 1'b0;
    rst = 1'b1;
    s_tvalid = 1'b0;
    s_tdata = '0;
    m_tready = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    failures = 0;
    cycles = 0;
    ticks_sent = 0;
    restarts_sent = 0;
    results_checked = 0;
    writes_done = 0;
    overflow_shown = 0;

    light_a = '{phase: PH_INIT, ticks: '0, rem: '0};
    light_b = '{phase: PH_INIT, ticks: '0, rem: '0};
    scan_cnt = SCAN_TICK_W'(SCAN_TICKS);
    second_cnt = SECOND_TICK_W'(SECOND_TICKS);
    digit_sel = '0;
    digit_shown = '0;
    digit_en = DIGITS_OFF;
    dur_red = MS_W'(RED_RESET_MS);
    dur_green = MS_W'(GREEN_RESET_MS);
    dur_yellow = MS_W'(YELLOW_RESET_MS);

    src_idle_pct = 34;
    sink_idle_pct = 60;
    repeat (6) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    test_directed_corners();
    test_short_phases();
    src_idle_pct = 60;
    sink_idle_pct = 34;
    test_long_red_overflow();
    src_idle_pct = 0;
    sink_idle_pct = 0;
    test_full_rate_mix();

    drain();
    repeat (4) @(negedge clk);
    $display("ran %0d ticks (%0d restarts), checked %0d results, %0d register writes",
             ticks_sent, restarts_sent, results_checked, writes_done);
    $display("saturated tens digit seen on %0d display scans", overflow_shown);
    if (failures == 0) begin
      $display("two_way_traffic_light_sequencer verification clean");
    end else begin
      $display("two_way_traffic_light_sequencer verification failed");
    end
    $finish;
  end

endmodule
